// ===== hw/rtl/ter_pkg.sv =====
// Shared types and constants for the triangle edge rasterizer.
package ter_pkg;

    // Defaults for the top-level parameters
    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 768;
    localparam int COORD_BITS_DEF    = 12;
    localparam int COORD_BITS_MAX    = 16;

    // Fixed widths of the item fields
    localparam int FIELD_BITS = 12;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Input item: a triangle load or a one-pixel step
    typedef struct packed {
        logic                         operation;
        logic signed [FIELD_BITS-1:0] vertex_a_x;
        logic signed [FIELD_BITS-1:0] vertex_a_y;
        logic signed [FIELD_BITS-1:0] vertex_b_x;
        logic signed [FIELD_BITS-1:0] vertex_b_y;
        logic signed [FIELD_BITS-1:0] vertex_c_x;
        logic signed [FIELD_BITS-1:0] vertex_c_y;
        logic [7:0]                   fill_colour;
    } t_tri_in;

    // Result item: one visited pixel
    typedef struct packed {
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [19:0] pixel_address;
        logic [7:0]  pixel_colour;
        logic        write_enable;
        logic        done_res;
    } t_pix_out;

endpackage

// ===== hw/rtl/triangle_edge_rasterizer.sv =====
// Top level of the triangle edge rasterizer: box walker and edge pipeline.
//
// Usage: a load item (operation 0) takes three signed vertices and a fill
// colour and sets up the triangle's bounding box, clipped to the screen.
// Each step item (operation 1) visits the next box pixel in row-major order
// and returns its coordinates, frame address, colour, a write flag when the
// pixel is inside or on an edge, and done on the last pixel of the box.
// A load answers with a zero pixel, done set only for an empty box; a step
// with nothing left to walk answers with done set and no write.
// Every item gives exactly one result item, in order.
// Channels: valid/stall on both sides; an item moves on a rising edge with
// valid high and stall low.
// Path: an accepted item passes the walker, product and result registers in
// that order. Throughput: one item per cycle while the receiver does not
// stall; the walker updates its cursor as each step item is accepted.
// Reset (synchronous, active low) empties the pipeline and leaves the block
// idle with nothing loaded. When the receiver stalls, the three stages fill
// up and then the input side stalls; no item is lost or repeated.
module triangle_edge_rasterizer #(
    parameter int SCREEN_WIDTH  = ter_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ter_pkg::SCREEN_HEIGHT_DEF,
    parameter int COORD_BITS    = ter_pkg::COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ter_pkg::t_tri_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ter_pkg::t_pix_out o_out_data
);
    import ter_pkg::*;

    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int YW = $clog2(SCREEN_HEIGHT);
    localparam int DW = COORD_BITS + 2;
    localparam logic signed [DW-1:0] X_MAX = DW'(SCREEN_WIDTH - 1);
    localparam logic signed [DW-1:0] Y_MAX = DW'(SCREEN_HEIGHT - 1);

    // Walker state
    logic signed [COORD_BITS-1:0] r_vx [3];
    logic signed [COORD_BITS-1:0] r_vy [3];
    logic [7:0]                   r_colour;
    logic [XW-1:0]                r_box_l;
    logic [XW-1:0]                r_box_r;
    logic [YW-1:0]                r_box_t;
    logic [YW-1:0]                r_box_b;
    logic [XW-1:0]                r_cur_x;
    logic [YW-1:0]                r_cur_y;
    logic                         r_walking;

    // Walker output register
    logic                 r_a_valid;
    t_pix_out             r_a_data;
    logic signed [DW-1:0] r_a_p [3];
    logic signed [DW-1:0] r_a_q [3];
    logic signed [DW-1:0] r_a_u [3];
    logic signed [DW-1:0] r_a_w [3];

    logic                         s_b_stall;
    logic                         s_en_a;
    logic                         s_acc;
    logic signed [COORD_BITS-1:0] s_vx [3];
    logic signed [COORD_BITS-1:0] s_vy [3];
    logic signed [DW-1:0]         s_ex [3];
    logic signed [DW-1:0]         s_ey [3];
    logic signed [DW-1:0]         s_lx;
    logic signed [DW-1:0]         s_hx;
    logic signed [DW-1:0]         s_ly;
    logic signed [DW-1:0]         s_hy;
    logic                         s_empty;
    logic                         s_last;
    logic [31:0]                  s_addr_full;
    logic signed [DW-1:0]         s_px;
    logic signed [DW-1:0]         s_py;
    logic signed [DW-1:0]         s_rx [3];
    logic signed [DW-1:0]         s_ry [3];
    t_pix_out                     n_a_data;

    // Field bits to a coordinate of COORD_BITS bits
    function automatic logic signed [COORD_BITS-1:0] to_coord(
        input logic [FIELD_BITS-1:0] f
    );
        logic [COORD_BITS_MAX-1:0] z;
        z = COORD_BITS_MAX'(f);
        return $signed(z[COORD_BITS-1:0]);
    endfunction

    // Handshake of the walker stage
    assign s_en_a     = !r_a_valid || !s_b_stall;
    assign o_in_stall = !s_en_a;
    assign s_acc      = i_in_valid && s_en_a;

    // Incoming vertices
    assign s_vx[0] = to_coord(i_in_data.vertex_a_x);
    assign s_vy[0] = to_coord(i_in_data.vertex_a_y);
    assign s_vx[1] = to_coord(i_in_data.vertex_b_x);
    assign s_vy[1] = to_coord(i_in_data.vertex_b_y);
    assign s_vx[2] = to_coord(i_in_data.vertex_c_x);
    assign s_vy[2] = to_coord(i_in_data.vertex_c_y);

    for (genvar k = 0; k < 3; k++) begin : g_ext
        assign s_ex[k] = DW'(s_vx[k]);
        assign s_ey[k] = DW'(s_vy[k]);
        assign s_rx[k] = DW'(r_vx[k]);
        assign s_ry[k] = DW'(r_vy[k]);
    end

    // Bounding box, clipped to the screen
    always_comb begin
        s_lx = s_ex[0];
        s_hx = s_ex[0];
        s_ly = s_ey[0];
        s_hy = s_ey[0];
        for (int k = 1; k < 3; k++) begin
            if (s_ex[k] < s_lx) s_lx = s_ex[k];
            if (s_ex[k] > s_hx) s_hx = s_ex[k];
            if (s_ey[k] < s_ly) s_ly = s_ey[k];
            if (s_ey[k] > s_hy) s_hy = s_ey[k];
        end
        if (s_lx < 0) s_lx = '0;
        if (s_ly < 0) s_ly = '0;
        if (s_hx > X_MAX) s_hx = X_MAX;
        if (s_hy > Y_MAX) s_hy = Y_MAX;
        s_empty = (s_lx > s_hx) || (s_ly > s_hy);
    end

    // Current pixel and its frame address
    assign s_last      = r_walking && (r_cur_x == r_box_r) && (r_cur_y == r_box_b);
    assign s_addr_full = 32'(r_cur_y) * 32'(SCREEN_WIDTH) + 32'(r_cur_x);
    assign s_px        = DW'($signed({1'b0, r_cur_x}));
    assign s_py        = DW'($signed({1'b0, r_cur_y}));

    // Result fields ahead of the edge test; write_enable marks a walked pixel
    always_comb begin
        n_a_data = '0;
        if (i_in_data.operation == OP_LOAD) begin
            n_a_data.done_res = s_empty;
        end else if (!r_walking) begin
            n_a_data.done_res = 1'b1;
        end else begin
            n_a_data.pixel_x       = 10'(r_cur_x);
            n_a_data.pixel_y       = 10'(r_cur_y);
            n_a_data.pixel_address = s_addr_full[19:0];
            n_a_data.pixel_colour  = r_colour;
            n_a_data.write_enable  = 1'b1;
            n_a_data.done_res      = s_last;
        end
    end

    // Triangle state and cursor walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_walking <= 1'b0;
            r_vx      <= '{default: '0};
            r_vy      <= '{default: '0};
            r_colour  <= '0;
            r_box_l   <= '0;
            r_box_r   <= '0;
            r_box_t   <= '0;
            r_box_b   <= '0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
        end else begin
            if (s_en_a) begin
                r_a_valid <= i_in_valid;
            end
            if (s_acc) begin
                if (i_in_data.operation == OP_LOAD) begin
                    r_vx     <= s_vx;
                    r_vy     <= s_vy;
                    r_colour <= i_in_data.fill_colour;
                    if (s_empty) begin
                        r_walking <= 1'b0;
                        r_box_l   <= '0;
                        r_box_r   <= '0;
                        r_box_t   <= '0;
                        r_box_b   <= '0;
                        r_cur_x   <= '0;
                        r_cur_y   <= '0;
                    end else begin
                        r_walking <= 1'b1;
                        r_box_l   <= s_lx[XW-1:0];
                        r_box_r   <= s_hx[XW-1:0];
                        r_box_t   <= s_ly[YW-1:0];
                        r_box_b   <= s_hy[YW-1:0];
                        r_cur_x   <= s_lx[XW-1:0];
                        r_cur_y   <= s_ly[YW-1:0];
                    end
                end else if (r_walking) begin
                    if (s_last) begin
                        r_walking <= 1'b0;
                    end else if (r_cur_x == r_box_r) begin
                        r_cur_x <= r_box_l;
                        r_cur_y <= r_cur_y + YW'(1);
                    end else begin
                        r_cur_x <= r_cur_x + XW'(1);
                    end
                end
            end
        end
    end

    // Edge factors for the visited pixel
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_a_data <= n_a_data;
            for (int k = 0; k < 3; k++) begin
                r_a_p[k] <= s_px - s_rx[k];
                r_a_q[k] <= s_py - s_ry[k];
                r_a_u[k] <= s_ry[(k + 1) % 3] - s_ry[k];
                r_a_w[k] <= s_rx[(k + 1) % 3] - s_rx[k];
            end
        end
    end

    ter_edge_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_valid),
        .o_stall (s_b_stall),
        .i_data  (r_a_data),
        .i_p     (r_a_p),
        .i_q     (r_a_q),
        .i_u     (r_a_u),
        .i_w     (r_a_w),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // Cursor never leaves the box during a walk
    a_cursor_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walking |-> (r_cur_x >= r_box_l && r_cur_x <= r_box_r &&
                       r_cur_y >= r_box_t && r_cur_y <= r_box_b))
        else $error("cursor outside the bounding box");

    // A load with a non-empty box starts at its top-left corner
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_in_data.operation == OP_LOAD && !s_empty) |=>
            (r_walking && r_cur_x == r_box_l && r_cur_y == r_box_t))
        else $error("load did not start the walk at the box corner");

    // The last pixel ends the walk
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_in_data.operation == OP_STEP && s_last) |=> !r_walking)
        else $error("walk continued past the last pixel");
`endif

endmodule

// ===== hw/rtl/ter_edge_pipe.sv =====
// Edge function products, sign test and result register of the rasterizer.
module ter_edge_pipe #(
    parameter int COORD_BITS = ter_pkg::COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  ter_pkg::t_pix_out        i_data,
    input  logic signed [COORD_BITS+1:0] i_p [3],
    input  logic signed [COORD_BITS+1:0] i_q [3],
    input  logic signed [COORD_BITS+1:0] i_u [3],
    input  logic signed [COORD_BITS+1:0] i_w [3],
    output logic                     o_valid,
    input  logic                     i_stall,
    output ter_pkg::t_pix_out        o_data
);
    import ter_pkg::*;

    localparam int DW = COORD_BITS + 2;
    localparam int PW = 2 * DW;
    localparam int EW = PW + 1;

    logic                 r_b_valid;
    t_pix_out             r_b_data;
    logic signed [PW-1:0] r_b_m0 [3];
    logic signed [PW-1:0] r_b_m1 [3];
    logic                 r_c_valid;
    t_pix_out             r_c_data;

    logic                 s_en_b;
    logic                 s_en_c;
    logic                 s_acc;
    logic signed [PW-1:0] s_m0 [3];
    logic signed [PW-1:0] s_m1 [3];
    logic signed [EW-1:0] s_e [3];
    logic                 s_neg;
    logic                 s_pos;
    t_pix_out             n_c_data;

    // Each stage moves when its successor has room
    assign s_en_c  = !r_c_valid || !i_stall;
    assign s_en_b  = !r_b_valid || s_en_c;
    assign o_stall = !s_en_b;
    assign s_acc   = i_valid && s_en_b;

    // Products of the edge functions of the triangle
    for (genvar k = 0; k < 3; k++) begin : g_mul
        assign s_m0[k] = i_p[k] * i_u[k];
        assign s_m1[k] = i_q[k] * i_w[k];
        assign s_e[k]  = EW'(r_b_m0[k]) - EW'(r_b_m1[k]);
    end

    // Inside unless the edge values carry both signs
    always_comb begin
        s_neg = 1'b0;
        s_pos = 1'b0;
        for (int k = 0; k < 3; k++) begin
            s_neg = s_neg | s_e[k][EW-1];
            s_pos = s_pos | (!s_e[k][EW-1] && (s_e[k] != '0));
        end
        n_c_data = r_b_data;
        n_c_data.write_enable = r_b_data.write_enable && !(s_neg && s_pos);
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (s_en_b) begin
                r_b_valid <= i_valid;
            end
            if (s_en_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_b_data <= i_data;
            r_b_m0   <= s_m0;
            r_b_m1   <= s_m1;
        end
        if (s_en_c && r_b_valid) begin
            r_c_data <= n_c_data;
        end
    end

    assign o_valid = r_c_valid;
    assign o_data  = r_c_data;

endmodule
